FILE: rtl/glyq_pkg.sv
// ----------------------------------------------------------------------------
// Glyph quad generator package
// Shared constants, types and helper functions for the glyph quad generator.
// ----------------------------------------------------------------------------
package glyq_pkg;

    localparam int GLYPH_COUNT = 256;
    // Character codes are eight bits wide, so no more than 256 entries are reachable.
    localparam int TABLE_DEPTH = (GLYPH_COUNT < 256) ? GLYPH_COUNT : 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 84;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEX_WIDTH     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEX_HEIGHT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LETTERS   = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef logic signed [16:0] pos_t;
    typedef logic [16:0]        tex_t;

    localparam tex_t TEX_ONE = 17'h10000;

    typedef enum logic [1:0] {
        JOB_UL,
        JOB_UR,
        JOB_VT,
        JOB_VB
    } div_job_t;

    typedef struct packed {
        logic       accept;
        logic       lookup;
        logic       calc;
        logic       div_start;
        div_job_t   div_job;
        logic       div_store;
        logic [1:0] corner;
        logic       advance;
    } dp_cmd_t;

    typedef struct packed {
        logic is_draw;
        logic drop;
        logic div_done;
    } dp_status_t;

    function automatic pos_t sat_pos(input logic signed [19:0] v);
        pos_t r;
        if (v < -20'sd65536)
        begin
            r = -17'sd65536;
        end
        else if (v > 20'sd65535)
        begin
            r = 17'sd65535;
        end
        else
        begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/glyq_if.sv
// ----------------------------------------------------------------------------
// Glyph quad generator channels
// Valid/ready channels for input items and output vertices.
// ----------------------------------------------------------------------------
interface glyq_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  code;
    logic        first;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [11:0] src_w;
    logic [11:0] src_h;
    logic signed [11:0] off_x;
    logic signed [11:0] off_y;
    logic signed [11:0] advance;

    modport source (output valid, cmd, code, first, src_x, src_y, src_w, src_h,
                    off_x, off_y, advance, input ready);
    modport sink (input valid, cmd, code, first, src_x, src_y, src_w, src_h,
                  off_x, off_y, advance, output ready);
endinterface

interface glyq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         corner;
    glyq_pkg::pos_t     pos_x;
    glyq_pkg::pos_t     pos_y;
    glyq_pkg::tex_t     tex_u;
    glyq_pkg::tex_t     tex_v;
    logic               last;

    modport source (output valid, corner, pos_x, pos_y, tex_u, tex_v, last, input ready);
    modport sink (input valid, corner, pos_x, pos_y, tex_u, tex_v, last, output ready);
endinterface

FILE: rtl/glyq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module glyq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/glyq_div.sv
// ----------------------------------------------------------------------------
// Texture coordinate divider
// Restoring divider giving floor(num * 65536 / den), saturated at 65536.
// ----------------------------------------------------------------------------
module glyq_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [12:0]    num,
    input  logic [12:0]    den,
    output logic           done,
    output glyq_pkg::tex_t quo
);
    import glyq_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic        sat_reg;
    logic [3:0]  step_reg;
    logic [12:0] rem_reg;
    logic [12:0] den_reg;
    logic [15:0] q_reg;
    logic [12:0] den_eff;
    logic [13:0] rem_dbl;

    assign den_eff = (den == 13'd0) ? 13'd1 : den;
    assign rem_dbl = {rem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // A quotient of one or more saturates, so only the fraction is iterated.
                if (num >= den_eff)
                begin
                    sat_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end
                else
                begin
                    sat_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                    step_reg <= 4'd15;
                end
            end
            else if (busy_reg)
            begin
                if (step_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den_eff;
            q_reg   <= 16'd0;
        end
        else if (busy_reg)
        begin
            if (rem_dbl >= {1'b0, den_reg})
            begin
                rem_reg <= 13'(rem_dbl - {1'b0, den_reg});
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_dbl[12:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = sat_reg ? TEX_ONE : {1'b0, q_reg};

endmodule

FILE: rtl/glyq_dp.sv
// ----------------------------------------------------------------------------
// Glyph quad datapath
// Configuration, glyph table, pen state, corner positions and texture coordinates.
// ----------------------------------------------------------------------------
module glyq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [glyq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [glyq_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          cmd,
    input  logic [7:0]                    code,
    input  logic                          first,
    input  logic [11:0]                   src_x,
    input  logic [11:0]                   src_y,
    input  logic [11:0]                   src_w,
    input  logic [11:0]                   src_h,
    input  logic signed [11:0]            off_x,
    input  logic signed [11:0]            off_y,
    input  logic signed [11:0]            advance,
    input  glyq_pkg::dp_cmd_t             dp_cmd,
    output glyq_pkg::dp_status_t          dp_status,
    output logic [1:0]                    corner,
    output glyq_pkg::pos_t                pos_x,
    output glyq_pkg::pos_t                pos_y,
    output glyq_pkg::tex_t                tex_u,
    output glyq_pkg::tex_t                tex_v,
    output logic                          last
);
    import glyq_pkg::*;

    logic [13:0] screen_w_reg;
    logic [13:0] screen_h_reg;
    logic [12:0] tex_w_reg;
    logic [12:0] tex_h_reg;
    logic [15:0] max_letters_reg;

    pos_t        pen_reg;
    logic [15:0] count_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   rd_ok_reg;
    logic                   in_range;
    logic                   wr_en;
    logic                   draw_accept;
    logic [IDX_W-1:0]       idx;
    logic [ENTRY_W-1:0]     wr_entry;
    logic [ENTRY_W-1:0]     rd_entry;

    logic [11:0]        sx_reg, sy_reg, sw_reg, sh_reg;
    logic signed [11:0] ox_reg, oy_reg, adv_reg;

    pos_t xl_reg, xr_reg, yt_reg, yb_reg;
    tex_t ul_reg, ur_reg, vt_reg, vb_reg;

    logic signed [19:0] xl_sum, xr_sum, yt_sum, yb_sum, pen_sum;
    logic [15:0]        eff_count;

    logic [12:0] div_num;
    logic [12:0] div_den;
    logic        div_done;
    tex_t        div_quo;

    assign in_range    = (32'(code) < GLYPH_COUNT);
    assign idx         = code[IDX_W-1:0];
    assign wr_en       = dp_cmd.accept && (cmd == CMD_LOAD) && in_range;
    assign draw_accept = dp_cmd.accept && (cmd == CMD_DRAW);
    assign wr_entry    = {advance, off_y, off_x, src_h, src_w, src_y, src_x};

    glyq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx),
        .wdata (wr_entry),
        .re    (draw_accept),
        .raddr (idx),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg    <= 14'd640;
            screen_h_reg    <= 14'd480;
            tex_w_reg       <= 13'd256;
            tex_h_reg       <= 13'd256;
            max_letters_reg <= 16'd65535;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  screen_w_reg    <= cfg_wdata[13:0];
                CFG_SCREEN_HEIGHT: screen_h_reg    <= cfg_wdata[13:0];
                CFG_TEX_WIDTH:     tex_w_reg       <= cfg_wdata[12:0];
                CFG_TEX_HEIGHT:    tex_h_reg       <= cfg_wdata[12:0];
                CFG_MAX_LETTERS:   max_letters_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Entries never loaded read as zeros through their valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (draw_accept)
            begin
                rd_ok_reg <= in_range && valid_reg[idx];
            end
        end
    end

    assign pen_sum   = 20'(pen_reg) + (20'(adv_reg) <<< 1);
    assign eff_count = first ? 16'd0 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg   <= '0;
            count_reg <= '0;
        end
        else if (draw_accept && first)
        begin
            pen_reg   <= -$signed({3'b000, screen_w_reg});
            count_reg <= 16'd0;
        end
        else if (dp_cmd.advance)
        begin
            pen_reg   <= sat_pos(pen_sum);
            count_reg <= count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.lookup)
        begin
            if (rd_ok_reg)
            begin
                {adv_reg, oy_reg, ox_reg, sh_reg, sw_reg, sy_reg, sx_reg} <= rd_entry;
            end
            else
            begin
                {adv_reg, oy_reg, ox_reg, sh_reg, sw_reg, sy_reg, sx_reg} <= '0;
            end
        end
    end

    assign xl_sum = 20'(pen_reg) + (20'(ox_reg) <<< 1);
    assign xr_sum = xl_sum + $signed({7'b0, sw_reg, 1'b0});
    assign yt_sum = $signed({6'b0, screen_h_reg}) - (20'(oy_reg) <<< 1);
    assign yb_sum = yt_sum - $signed({7'b0, sh_reg, 1'b0});

    always_ff @(posedge clk)
    begin
        if (dp_cmd.calc)
        begin
            xl_reg <= sat_pos(xl_sum);
            xr_reg <= sat_pos(xr_sum);
            yt_reg <= sat_pos(yt_sum);
            yb_reg <= sat_pos(yb_sum);
        end
    end

    always_comb
    begin
        case (dp_cmd.div_job)
            JOB_UL:
            begin
                div_num = {1'b0, sx_reg};
                div_den = tex_w_reg;
            end
            JOB_UR:
            begin
                div_num = {1'b0, sx_reg} + {1'b0, sw_reg};
                div_den = tex_w_reg;
            end
            JOB_VT:
            begin
                div_num = {1'b0, sy_reg};
                div_den = tex_h_reg;
            end
            JOB_VB:
            begin
                div_num = {1'b0, sy_reg} + {1'b0, sh_reg};
                div_den = tex_h_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = tex_w_reg;
            end
        endcase
    end

    glyq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dp_cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (dp_cmd.div_store && div_done)
        begin
            case (dp_cmd.div_job)
                JOB_UL:  ul_reg <= div_quo;
                JOB_UR:  ur_reg <= div_quo;
                JOB_VT:  vt_reg <= div_quo;
                JOB_VB:  vb_reg <= div_quo;
                default: ;
            endcase
        end
    end

    assign dp_status.is_draw  = (cmd == CMD_DRAW);
    assign dp_status.drop     = (eff_count >= max_letters_reg);
    assign dp_status.div_done = div_done;

    assign corner = dp_cmd.corner;
    assign pos_x  = dp_cmd.corner[0] ? xr_reg : xl_reg;
    assign pos_y  = dp_cmd.corner[1] ? yb_reg : yt_reg;
    assign tex_u  = dp_cmd.corner[0] ? ur_reg : ul_reg;
    assign tex_v  = dp_cmd.corner[1] ? vb_reg : vt_reg;
    assign last   = (dp_cmd.corner == CORNER_BR);

endmodule

FILE: rtl/glyq_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph quad controller
// Sequences table lookup, position set-up, divisions and vertex output.
// ----------------------------------------------------------------------------
module glyq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 vertex_valid,
    input  logic                 vertex_ready,
    input  glyq_pkg::dp_status_t dp_status,
    output glyq_pkg::dp_cmd_t    dp_cmd
);
    import glyq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CALC,
        S_DSTART,
        S_DWAIT,
        S_EMIT
    } state_t;

    state_t     state_reg;
    div_job_t   job_reg;
    logic [1:0] corner_reg;
    logic       accept;

    assign item_ready   = (state_reg == S_IDLE);
    assign vertex_valid = (state_reg == S_EMIT);
    assign accept       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            job_reg    <= JOB_UL;
            corner_reg <= 2'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && dp_status.is_draw && !dp_status.drop)
                    begin
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    job_reg   <= JOB_UL;
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (dp_status.div_done)
                    begin
                        if (job_reg == JOB_VB)
                        begin
                            corner_reg <= 2'd0;
                            state_reg  <= S_EMIT;
                        end
                        else
                        begin
                            job_reg   <= div_job_t'(job_reg + 2'd1);
                            state_reg <= S_DSTART;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (vertex_ready)
                    begin
                        if (corner_reg == CORNER_BR)
                        begin
                            state_reg <= S_IDLE;
                        end
                        corner_reg <= corner_reg + 2'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign dp_cmd.accept    = accept;
    assign dp_cmd.lookup    = (state_reg == S_LOOKUP);
    assign dp_cmd.calc      = (state_reg == S_CALC);
    assign dp_cmd.div_start = (state_reg == S_DSTART);
    assign dp_cmd.div_job   = job_reg;
    assign dp_cmd.div_store = (state_reg == S_DWAIT);
    assign dp_cmd.corner    = corner_reg;
    assign dp_cmd.advance   = (state_reg == S_EMIT) && vertex_ready
                              && (corner_reg == CORNER_BR);

endmodule

FILE: rtl/glyph_quad_generator.sv
// ----------------------------------------------------------------------------
// Glyph quad generator
// A load item is taken while the block is idle and leaves it idle. A draw
// item goes through a lookup step, a set-up step, then four divisions in
// turn on one shared divider (shorter when the coordinate saturates). Its
// four vertices then go out one a cycle while the sink takes them, and the
// input is held until the last is taken. A dropped draw leaves the block
// idle. Reset is asynchronous, active low; the table reads as zeros after
// it.
// ----------------------------------------------------------------------------
module glyph_quad_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [glyq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [glyq_pkg::CFG_W-1:0]      cfg_wdata,
    glyq_in_if.sink                         item,
    glyq_out_if.source                      vertex
);
    import glyq_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    glyq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .vertex_valid (vertex.valid),
        .vertex_ready (vertex.ready),
        .dp_status    (dp_status),
        .dp_cmd       (dp_cmd)
    );

    glyq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (item.cmd),
        .code      (item.code),
        .first     (item.first),
        .src_x     (item.src_x),
        .src_y     (item.src_y),
        .src_w     (item.src_w),
        .src_h     (item.src_h),
        .off_x     (item.off_x),
        .off_y     (item.off_y),
        .advance   (item.advance),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .corner    (vertex.corner),
        .pos_x     (vertex.pos_x),
        .pos_y     (vertex.pos_y),
        .tex_u     (vertex.tex_u),
        .tex_v     (vertex.tex_v),
        .last      (vertex.last)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Glyph quad generator testbench
// Loads glyph table entries and draws strings of characters through the item
// channel. Each draw is predicted as four corner vertices and checked beat by
// beat against the vertex channel. Several register settings, the extremes
// among them, are exercised with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import glyq_pkg::*;

    typedef struct {
        logic               cmd;
        logic [7:0]         code;
        logic               first;
        logic [11:0]        src_x;
        logic [11:0]        src_y;
        logic [11:0]        src_w;
        logic [11:0]        src_h;
        logic signed [11:0] off_x;
        logic signed [11:0] off_y;
        logic signed [11:0] advance;
    } glyph_item_t;

    typedef struct {
        logic [1:0] corner;
        pos_t       pos_x;
        pos_t       pos_y;
        tex_t       tex_u;
        tex_t       tex_v;
        logic       last;
    } vertex_t;

    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    glyq_in_if  item ();
    glyq_out_if vertex ();

    glyph_quad_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item.sink),
        .vertex    (vertex.source)
    );

    glyph_item_t pending_items[$];
    vertex_t     expected_vertices[$];
    int          errors = 0;

    // Shadow of the block's table, pen and registers.
    logic [11:0]        tbl_sx[256]  = '{default: '0};
    logic [11:0]        tbl_sy[256]  = '{default: '0};
    logic [11:0]        tbl_sw[256]  = '{default: '0};
    logic [11:0]        tbl_sh[256]  = '{default: '0};
    logic signed [11:0] tbl_ox[256]  = '{default: '0};
    logic signed [11:0] tbl_oy[256]  = '{default: '0};
    logic signed [11:0] tbl_adv[256] = '{default: '0};
    int                 pen = 0;
    int                 letters = 0;
    int                 scr_w = 640;
    int                 scr_h = 480;
    int                 tex_w = 256;
    int                 tex_h = 256;
    int                 letter_limit = 65535;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic pos_t clamp_pos(input int v);
        if (v < -65536)
        begin
            return -17'sd65536;
        end
        if (v > 65535)
        begin
            return 17'sd65535;
        end
        return v[16:0];
    endfunction

    function automatic tex_t tex_frac(input int texel, input int size);
        longint d;
        longint q;
        d = (size == 0) ? 1 : size;
        q = (longint'(texel) << 16) / d;
        return (q > 65536) ? TEX_ONE : tex_t'(q);
    endfunction

    function automatic void quad_for_item(input glyph_item_t it);
        int      c;
        pos_t    xl, xr, yt, yb;
        tex_t    ul, ur, vt, vb;
        vertex_t v;
        c = int'(it.code);
        if (it.cmd == CMD_LOAD)
        begin
            tbl_sx[c] = it.src_x;
            tbl_sy[c] = it.src_y;
            tbl_sw[c] = it.src_w;
            tbl_sh[c] = it.src_h;
            tbl_ox[c] = it.off_x;
            tbl_oy[c] = it.off_y;
            tbl_adv[c] = it.advance;
            return;
        end
        if (it.first)
        begin
            pen = -scr_w;
            letters = 0;
        end
        if (letters >= letter_limit)
        begin
            return;
        end
        xl = clamp_pos(pen + 2 * int'(tbl_ox[c]));
        xr = clamp_pos(pen + 2 * int'(tbl_ox[c]) + 2 * int'(tbl_sw[c]));
        yt = clamp_pos(scr_h - 2 * int'(tbl_oy[c]));
        yb = clamp_pos(scr_h - 2 * int'(tbl_oy[c]) - 2 * int'(tbl_sh[c]));
        ul = tex_frac(int'(tbl_sx[c]), tex_w);
        ur = tex_frac(int'(tbl_sx[c]) + int'(tbl_sw[c]), tex_w);
        vt = tex_frac(int'(tbl_sy[c]), tex_h);
        vb = tex_frac(int'(tbl_sy[c]) + int'(tbl_sh[c]), tex_h);
        for (int k = 0; k < 4; k++)
        begin
            v.corner = k[1:0];
            v.pos_x  = k[0] ? xr : xl;
            v.pos_y  = k[1] ? yb : yt;
            v.tex_u  = k[0] ? ur : ul;
            v.tex_v  = k[1] ? vb : vt;
            v.last   = (k[1:0] == CORNER_BR);
            expected_vertices.push_back(v);
        end
        pen = int'(clamp_pos(pen + 2 * int'(tbl_adv[c])));
        letters = (letters + 1) & 16'hFFFF;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        glyph_item_t it;
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.cmd <= CMD_LOAD;
            item.code <= '0;
            item.first <= 1'b0;
            item.src_x <= '0;
            item.src_y <= '0;
            item.src_w <= '0;
            item.src_h <= '0;
            item.off_x <= '0;
            item.off_y <= '0;
            item.advance <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else if (!(item.valid && !item.ready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                item.cmd <= it.cmd;
                item.code <= it.code;
                item.first <= it.first;
                item.src_x <= it.src_x;
                item.src_y <= it.src_y;
                item.src_w <= it.src_w;
                item.src_h <= it.src_h;
                item.off_x <= it.off_x;
                item.off_y <= it.off_y;
                item.advance <= it.advance;
                item.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                item.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall mode changes every so often; a long hold-off on request.
    logic hold_req;
    logic hold_seen;
    int   hold_left;
    int   stall_mode;
    int   mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex.ready <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 120);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            if (hold_left > 0)
            begin
                vertex.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: vertex.ready <= 1'b1;
                    1: vertex.ready <= ($urandom_range(0, 3) != 0);
                    default: vertex.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: shadows register writes, predicts accepted items, checks vertices.
    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_SCREEN_WIDTH:  scr_w = int'(cfg_wdata & 16'h3FFF);
                    CFG_SCREEN_HEIGHT: scr_h = int'(cfg_wdata & 16'h3FFF);
                    CFG_TEX_WIDTH:     tex_w = int'(cfg_wdata & 16'h1FFF);
                    CFG_TEX_HEIGHT:    tex_h = int'(cfg_wdata & 16'h1FFF);
                    CFG_MAX_LETTERS:   letter_limit = int'(cfg_wdata);
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                quad_for_item('{item.cmd, item.code, item.first, item.src_x, item.src_y,
                                item.src_w, item.src_h, item.off_x, item.off_y,
                                item.advance});
            end
            if (vertex.valid && vertex.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    report_mismatch("unexpected vertex, corner", vertex.corner, -1);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (vertex.corner !== want.corner)
                        report_mismatch("corner", vertex.corner, want.corner);
                    if (vertex.pos_x !== want.pos_x)
                        report_mismatch("pos_x", vertex.pos_x, want.pos_x);
                    if (vertex.pos_y !== want.pos_y)
                        report_mismatch("pos_y", vertex.pos_y, want.pos_y);
                    if (vertex.tex_u !== want.tex_u)
                        report_mismatch("tex_u", vertex.tex_u, want.tex_u);
                    if (vertex.tex_v !== want.tex_v)
                        report_mismatch("tex_v", vertex.tex_v, want.tex_v);
                    if (vertex.last !== want.last)
                        report_mismatch("last", vertex.last, want.last);
                end
            end
        end
    end

    int cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("glyph_quad_generator: mismatch");
            $finish;
        end
    end

    task automatic push_load(input int code, input int sx, input int sy, input int sw,
                             input int sh, input int ox, input int oy, input int adv);
        glyph_item_t it;
        it.cmd = CMD_LOAD;
        it.code = 8'(code);
        it.first = 1'($urandom_range(0, 1));
        it.src_x = 12'(sx);
        it.src_y = 12'(sy);
        it.src_w = 12'(sw);
        it.src_h = 12'(sh);
        it.off_x = 12'(ox);
        it.off_y = 12'(oy);
        it.advance = 12'(adv);
        pending_items.push_back(it);
    endtask

    task automatic push_draw(input int code, input bit first);
        glyph_item_t it;
        it.cmd = CMD_DRAW;
        it.code = 8'(code);
        it.first = first;
        // Load-only fields carry noise on draws.
        it.src_x = 12'($urandom);
        it.src_y = 12'($urandom);
        it.src_w = 12'($urandom);
        it.src_h = 12'($urandom);
        it.off_x = 12'($urandom);
        it.off_y = 12'($urandom);
        it.advance = 12'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_random_load(input int code);
        push_load(code, $urandom, $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64),
                  $urandom, $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_results;
        do
        begin
            @(posedge clk);
        end
        while (pending_items.size() > 0 || item.valid || expected_vertices.size() > 0);
    endtask

    task automatic wait_idle;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic setup(input int sw, input int sh, input int tw, input int th, input int ml);
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
        write_reg(CFG_TEX_WIDTH, tw);
        write_reg(CFG_TEX_HEIGHT, th);
        write_reg(CFG_MAX_LETTERS, ml);
    endtask

    // Random strings: a few table loads, then a string of draws, with some noise.
    task automatic random_strings(input int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_draw($urandom_range(0, 255), 1'($urandom_range(0, 1)));
                n++;
            end
            else
            begin
                for (int i = $urandom_range(0, 3); i > 0; i--)
                begin
                    push_random_load($urandom_range(0, 15));
                    n++;
                end
                for (int i = $urandom_range(1, 6); i > 0; i--)
                begin
                    push_draw(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 15), 1'b0);
                    n++;
                end
                pending_items[pending_items.size() - 1].first = 1'b0;
            end
        end
    endtask

    task automatic random_phase(input int count);
        int mark;
        mark = pending_items.size();
        random_strings(count);
        // Make most strings start properly: the first draw after the loads opens one.
        for (int i = mark; i < pending_items.size(); i++)
        begin
            if (pending_items[i].cmd == CMD_DRAW && (i == mark || pending_items[i - 1].cmd == CMD_LOAD))
                pending_items[i].first = ($urandom_range(0, 7) != 0);
        end
    endtask

    initial
    begin
        hold_req = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a draw before any string start uses a pen at zero, on an
        // unloaded code; then extreme entries and pen saturation at the negative end.
        push_draw(7, 0);
        push_load(0, 4095, 4095, 4095, 4095, 2047, 2047, 2047);
        push_load(255, 0, 0, 0, 0, -2048, -2048, -2048);
        push_load(1, 100, 50, 20, 30, -3, 5, 12);
        push_draw(0, 1);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(0, 0);
        push_draw(255, 1);
        for (int i = 0; i < 18; i++)
            push_draw(255, 0);
        push_draw(1, 1);
        push_draw(200, 0);
        wait_idle();

        // Large screen and texture sizes.
        setup(8192, 8192, 4096, 4096, 65535);
        random_phase(55);
        wait_idle();

        // Smallest sizes, no letters allowed at all.
        setup(1, 1, 1, 1, 0);
        push_draw(0, 1);
        push_draw(1, 0);
        random_phase(30);
        wait_idle();

        // Zero texture size counts as one; short letter limit.
        setup(100, 3000, 0, 0, 3);
        random_phase(55);
        // The sender pauses until every vertex has come, then goes on.
        wait_results();
        random_phase(20);
        wait_idle();

        // Random sizes, with a long receiver hold-off while items keep coming.
        setup($urandom_range(1, 8192), $urandom_range(1, 8192), $urandom_range(1, 4096),
              $urandom_range(1, 4096), $urandom_range(1, 8));
        random_phase(60);
        repeat (30) @(posedge clk);
        hold_req = ~hold_req;
        wait_idle();

        setup($urandom_range(1, 8192), $urandom_range(1, 8192), $urandom_range(1, 4096),
              $urandom_range(1, 4096), 65535);
        random_phase(60);
        wait_idle();

        setup(640, 480, 256, 256, $urandom_range(1, 65535));
        random_phase(60);
        wait_idle();

        if (errors == 0)
        begin
            $display("glyph_quad_generator: match");
        end
        else
        begin
            $display("glyph_quad_generator: mismatch");
        end
        $finish;
    end
endmodule
